// ===== design/branch_call_return_cycle_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Branch/call/return cycle unit assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BRANCH_CALL_RETURN_CYCLE_UNIT_ASSERT_SVH
`define BRANCH_CALL_RETURN_CYCLE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Branch/call/return cycle unit package
// Instruction and bus cycle codes, item and state types.
// ----------------------------------------------------------------------------
package bcr_pkg;

    typedef enum logic [2:0] {
        FUNC_JR   = 3'd0,
        FUNC_RET  = 3'd1,
        FUNC_RETC = 3'd2,
        FUNC_JP   = 3'd3,
        FUNC_CALL = 3'd4,
        FUNC_RST  = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        KIND_FETCH    = 2'd0,
        KIND_READ     = 2'd1,
        KIND_WRITE    = 2'd2,
        KIND_INTERNAL = 2'd3
    } bus_kind_t;

    typedef enum logic [2:0] {
        CYC_1 = 3'd1,
        CYC_2 = 3'd2,
        CYC_3 = 3'd3,
        CYC_4 = 3'd4,
        CYC_5 = 3'd5
    } cycle_t;

    typedef struct packed {
        logic [2:0]  func;
        logic        cond_true;
        logic [2:0]  cycle_index;
        logic [7:0]  read_byte;
        logic [7:0]  restart_target;
        logic [15:0] pc_in;
        logic [15:0] sp_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  next_bus_kind;
        logic [15:0] bus_address;
        logic [7:0]  write_byte;
        logic [15:0] pc_out;
        logic [15:0] sp_out;
        logic        int_align;
        logic        finished;
    } out_item_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] temp;
        bus_kind_t   kind;
        logic [7:0]  wdata;
    } cpu_state_t;

endpackage

// ===== design/bcr_if.sv =====
// ----------------------------------------------------------------------------
// Branch/call/return cycle unit channels
// Valid/ready channels for the input item and the result item.
// ----------------------------------------------------------------------------
interface bcr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic        cond_true;
    logic [2:0]  cycle_index;
    logic [7:0]  read_byte;
    logic [7:0]  restart_target;
    logic [15:0] pc_in;
    logic [15:0] sp_in;

    modport source (
        output valid, func, cond_true, cycle_index, read_byte, restart_target,
               pc_in, sp_in,
        input  ready
    );
    modport sink (
        input  valid, func, cond_true, cycle_index, read_byte, restart_target,
               pc_in, sp_in,
        output ready
    );
endinterface

interface bcr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  next_bus_kind;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
    logic [15:0] pc_out;
    logic [15:0] sp_out;
    logic        int_align;
    logic        finished;

    modport source (
        output valid, next_bus_kind, bus_address, write_byte, pc_out, sp_out,
               int_align, finished,
        input  ready
    );
    modport sink (
        input  valid, next_bus_kind, bus_address, write_byte, pc_out, sp_out,
               int_align, finished,
        output ready
    );
endinterface

// ===== design/branch_call_return_cycle_unit.sv =====
// ----------------------------------------------------------------------------
// Branch/call/return cycle unit
// Runs one machine cycle of a jump, call, return or restart per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one machine cycle: instruction code, condition, cycle
//   number, last read byte, restart target, PC and SP. out_ch returns one
//   result item per input item: next bus kind, bus address, write byte,
//   new PC and SP, interrupt alignment and instruction-finished flags.
//   The unit holds the address register, the 16-bit temporary, the bus kind
//   and the write byte across items; they change when an item is taken.
//   The result is registered and valid on the cycle after the input item is
//   taken. Throughput: one item per cycle while out_ch.ready is high, set by
//   the single result register behind combinational next-state logic.
//   Stall: while a result waits, in_ch.ready stays high only if out_ch.ready
//   is high, so the result register is drained and refilled in the same cycle.
//   Reset: address, temporary and write byte clear to zero, bus kind goes
//   to fetch and no result is pending.
// ----------------------------------------------------------------------------
`include "branch_call_return_cycle_unit_assert.svh"

module branch_call_return_cycle_unit
    import bcr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bcr_in_if.sink           in_ch,
    bcr_out_if.source        out_ch
);

    cpu_state_t state_reg;
    cpu_state_t state_next;
    in_item_t   item;
    out_item_t  res_next;
    out_item_t  res_reg;
    logic       out_valid_reg;
    logic       in_take;

    assign item.func           = in_ch.func;
    assign item.cond_true      = in_ch.cond_true;
    assign item.cycle_index    = in_ch.cycle_index;
    assign item.read_byte      = in_ch.read_byte;
    assign item.restart_target = in_ch.restart_target;
    assign item.pc_in          = in_ch.pc_in;
    assign item.sp_in          = in_ch.sp_in;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_take     = in_ch.valid && in_ch.ready;

    bcr_step u_step (
        .st      (state_reg),
        .item    (item),
        .st_next (state_next),
        .res     (res_next)
    );

    // advance machine state on each taken item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.addr  <= 16'h0000;
            state_reg.temp  <= 16'h0000;
            state_reg.kind  <= KIND_FETCH;
            state_reg.wdata <= 8'h00;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold result until taken
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.next_bus_kind = res_reg.next_bus_kind;
    assign out_ch.bus_address   = res_reg.bus_address;
    assign out_ch.write_byte    = res_reg.write_byte;
    assign out_ch.pc_out        = res_reg.pc_out;
    assign out_ch.sp_out        = res_reg.sp_out;
    assign out_ch.int_align     = res_reg.int_align;
    assign out_ch.finished      = res_reg.finished;

    `BCR_ASSERT_SAME(a_no_take_on_stall, out_valid_reg && !out_ch.ready, !in_ch.ready, "item taken while result stalled")
    `BCR_ASSERT_NEXT(a_take_gives_result, in_take, out_valid_reg, "taken item gave no result")
    `BCR_ASSERT_SAME(a_finish_is_fetch, out_valid_reg && res_reg.finished, res_reg.next_bus_kind == KIND_FETCH, "finished without fetch")
    `BCR_ASSERT_NEXT(a_state_held_idle, !in_take, $stable(state_reg), "state moved without an item")

endmodule

// ===== design/bcr_step.sv =====
// ----------------------------------------------------------------------------
// Branch/call/return cycle step
// Next machine state and result for one machine cycle of one instruction.
// ----------------------------------------------------------------------------
module bcr_step
    import bcr_pkg::*;
(
    input  cpu_state_t st,
    input  in_item_t   item,
    output cpu_state_t st_next,
    output out_item_t  res
);

    logic [15:0] addr_inc;
    logic [15:0] addr_dec;
    logic [15:0] pc_inc;
    logic [15:0] sp_dec;
    logic [15:0] rd_sext;
    logic [15:0] temp_hi;
    logic [15:0] pc_rel;
    logic [15:0] pc_val;
    logic [15:0] sp_val;
    logic        align;
    logic        done;

    assign addr_inc = st.addr + 16'd1;
    assign addr_dec = st.addr - 16'd1;
    assign pc_inc   = item.pc_in + 16'd1;
    assign sp_dec   = item.sp_in - 16'd1;
    assign rd_sext  = {{8{item.read_byte[7]}}, item.read_byte};
    assign temp_hi  = st.temp + {item.read_byte, 8'h00};
    assign pc_rel   = item.pc_in + rd_sext;

    always_comb
    begin
        st_next = st;
        pc_val  = item.pc_in;
        sp_val  = item.sp_in;
        align   = 1'b0;
        done    = 1'b0;
        case (func_t'(item.func))
            FUNC_JR:
            begin
                case (cycle_t'(item.cycle_index))
                    CYC_1:
                    begin
                        st_next.kind = KIND_READ;
                        st_next.addr = item.pc_in;
                        pc_val       = pc_inc;
                    end
                    CYC_2:
                    begin
                        if (!item.cond_true)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            st_next.kind = KIND_INTERNAL;
                        end
                    end
                    CYC_3:
                    begin
                        align  = 1'b1;
                        pc_val = pc_rel;
                        done   = 1'b1;
                    end
                    default: ;
                endcase
            end
            FUNC_RET:
            begin
                case (cycle_t'(item.cycle_index))
                    CYC_1:
                    begin
                        st_next.kind = KIND_READ;
                        st_next.addr = item.sp_in;
                    end
                    CYC_2:
                    begin
                        st_next.temp = {8'h00, item.read_byte};
                        st_next.addr = addr_inc;
                    end
                    CYC_3:
                    begin
                        align        = 1'b1;
                        st_next.temp = temp_hi;
                        st_next.addr = addr_inc;
                        sp_val       = addr_inc;
                        pc_val       = temp_hi;
                        done         = 1'b1;
                    end
                    default: ;
                endcase
            end
            FUNC_RETC:
            begin
                case (cycle_t'(item.cycle_index))
                    CYC_1:
                    begin
                        st_next.kind = KIND_READ;
                        st_next.addr = item.sp_in;
                    end
                    CYC_2:
                    begin
                        done         = !item.cond_true;
                        st_next.temp = {8'h00, item.read_byte};
                        st_next.addr = addr_inc;
                    end
                    CYC_3:
                    begin
                        st_next.temp = temp_hi;
                        st_next.addr = addr_inc;
                        st_next.kind = KIND_INTERNAL;
                    end
                    CYC_4:
                    begin
                        align  = 1'b1;
                        sp_val = st.addr;
                        pc_val = st.temp;
                        done   = 1'b1;
                    end
                    default: ;
                endcase
            end
            FUNC_JP:
            begin
                case (cycle_t'(item.cycle_index))
                    CYC_1:
                    begin
                        st_next.kind = KIND_READ;
                        st_next.addr = item.pc_in;
                        pc_val       = pc_inc;
                    end
                    CYC_2:
                    begin
                        st_next.temp = {8'h00, item.read_byte};
                        st_next.addr = item.pc_in;
                        pc_val       = pc_inc;
                    end
                    CYC_3:
                    begin
                        align        = 1'b1;
                        st_next.addr = addr_inc;
                        if (item.cond_true)
                        begin
                            pc_val = {item.read_byte, st.temp[7:0]};
                        end
                        done = 1'b1;
                    end
                    default: ;
                endcase
            end
            FUNC_CALL:
            begin
                case (cycle_t'(item.cycle_index))
                    CYC_1:
                    begin
                        st_next.kind = KIND_READ;
                        st_next.addr = item.pc_in;
                    end
                    CYC_2:
                    begin
                        st_next.temp = {st.temp[15:8], item.read_byte};
                        st_next.addr = addr_inc;
                    end
                    CYC_3:
                    begin
                        align        = 1'b1;
                        st_next.temp = {item.read_byte, st.temp[7:0]};
                        pc_val       = addr_inc;
                        if (item.cond_true)
                        begin
                            st_next.kind  = KIND_WRITE;
                            st_next.addr  = sp_dec;
                            st_next.wdata = addr_inc[15:8];
                        end
                        else
                        begin
                            st_next.addr = addr_inc;
                            done         = 1'b1;
                        end
                    end
                    CYC_4:
                    begin
                        st_next.addr  = addr_dec;
                        st_next.wdata = item.pc_in[7:0];
                    end
                    CYC_5:
                    begin
                        sp_val = st.addr;
                        pc_val = st.temp;
                        done   = 1'b1;
                    end
                    default: ;
                endcase
            end
            FUNC_RST:
            begin
                case (cycle_t'(item.cycle_index))
                    CYC_1:
                    begin
                        st_next.kind  = KIND_WRITE;
                        st_next.addr  = sp_dec;
                        st_next.wdata = item.pc_in[15:8];
                    end
                    CYC_2:
                    begin
                        st_next.addr  = addr_dec;
                        st_next.wdata = item.pc_in[7:0];
                    end
                    CYC_3:
                    begin
                        st_next.kind = KIND_INTERNAL;
                        sp_val       = st.addr;
                    end
                    CYC_4:
                    begin
                        pc_val = {8'h00, item.restart_target};
                        align  = 1'b1;
                    end
                    CYC_5:
                    begin
                        done = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (done)
        begin
            st_next.kind = KIND_FETCH;
        end
    end

    always_comb
    begin
        res.next_bus_kind = st_next.kind;
        res.bus_address   = st_next.addr;
        res.write_byte    = st_next.wdata;
        res.pc_out        = pc_val;
        res.sp_out        = sp_val;
        res.int_align     = align;
        res.finished      = done;
    end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Branch/call/return cycle unit testbench
// Drives machine cycles of jumps, calls, returns and restarts through the
// input channel, predicts each result from a cycle-level model of the unit's
// registers and compares every returned item field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import bcr_pkg::*;

    localparam logic [2:0] FUNC_BAD_6 = 3'd6;
    localparam logic [2:0] FUNC_BAD_7 = 3'd7;
    localparam logic [2:0] CYC_NONE   = 3'd0;
    localparam logic [2:0] CYC_7      = 3'd7;
    localparam int         RANDOM_ITEMS = 1500;
    localparam int         IDLE_LIMIT   = 2000;

    logic clk;
    logic rst_n;

    bcr_in_if  in_ch();
    bcr_out_if out_ch();

    branch_call_return_cycle_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    cpu_state_t cpu = '{addr: 16'h0000, temp: 16'h0000, kind: KIND_FETCH, wdata: 8'h00};
    out_item_t  pending_results[$];
    logic [15:0] cur_pc = 16'h0000;
    logic [15:0] cur_sp = 16'h0000;
    int errors       = 0;
    int active_items = 0;
    int burst_left   = 0;
    int idle_cycles  = 0;
    int stall_mode   = 0;
    int stall_phase  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [2:0] last_cycle(func_t f, logic cond);
        case (f)
            FUNC_JR:   return cond ? CYC_3 : CYC_2;
            FUNC_RET:  return CYC_3;
            FUNC_RETC: return cond ? CYC_4 : CYC_2;
            FUNC_JP:   return CYC_3;
            FUNC_CALL: return cond ? CYC_5 : CYC_3;
            default:   return CYC_5;
        endcase
    endfunction

    function automatic bit is_active(in_item_t item);
        if (item.func > FUNC_RST || item.cycle_index < CYC_1)
            return 1'b0;
        return item.cycle_index <= last_cycle(func_t'(item.func), 1'b1);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001;
            3:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic out_item_t predict_cycle(in_item_t item);
        out_item_t   r;
        logic [15:0] pc;
        logic [15:0] sp;
        logic        align;
        logic        done;
        pc    = item.pc_in;
        sp    = item.sp_in;
        align = 1'b0;
        done  = 1'b0;
        case (item.func)
            FUNC_JR:
            begin
                if (item.cycle_index == CYC_1)
                begin
                    cpu.kind = KIND_READ;
                    cpu.addr = pc;
                    pc       = pc + 16'd1;
                end
                else if (item.cycle_index == CYC_2)
                begin
                    if (!item.cond_true)
                        done = 1'b1;
                    else
                        cpu.kind = KIND_INTERNAL;
                end
                else if (item.cycle_index == CYC_3)
                begin
                    align = 1'b1;
                    pc    = pc + {{8{item.read_byte[7]}}, item.read_byte};
                    done  = 1'b1;
                end
            end
            FUNC_RET:
            begin
                if (item.cycle_index == CYC_1)
                begin
                    cpu.kind = KIND_READ;
                    cpu.addr = sp;
                end
                else if (item.cycle_index == CYC_2)
                begin
                    cpu.temp = {8'h00, item.read_byte};
                    cpu.addr = cpu.addr + 16'd1;
                end
                else if (item.cycle_index == CYC_3)
                begin
                    align    = 1'b1;
                    cpu.temp = cpu.temp + {item.read_byte, 8'h00};
                    cpu.addr = cpu.addr + 16'd1;
                    sp       = cpu.addr;
                    pc       = cpu.temp;
                    done     = 1'b1;
                end
            end
            FUNC_RETC:
            begin
                if (item.cycle_index == CYC_1)
                begin
                    cpu.kind = KIND_READ;
                    cpu.addr = sp;
                end
                else if (item.cycle_index == CYC_2)
                begin
                    // temporary and address move even when the condition fails
                    if (!item.cond_true)
                        done = 1'b1;
                    cpu.temp = {8'h00, item.read_byte};
                    cpu.addr = cpu.addr + 16'd1;
                end
                else if (item.cycle_index == CYC_3)
                begin
                    cpu.temp = cpu.temp + {item.read_byte, 8'h00};
                    cpu.addr = cpu.addr + 16'd1;
                    cpu.kind = KIND_INTERNAL;
                end
                else if (item.cycle_index == CYC_4)
                begin
                    align = 1'b1;
                    sp    = cpu.addr;
                    pc    = cpu.temp;
                    done  = 1'b1;
                end
            end
            FUNC_JP:
            begin
                if (item.cycle_index == CYC_1)
                begin
                    cpu.kind = KIND_READ;
                    cpu.addr = pc;
                    pc       = pc + 16'd1;
                end
                else if (item.cycle_index == CYC_2)
                begin
                    cpu.temp = {8'h00, item.read_byte};
                    cpu.addr = pc;
                    pc       = pc + 16'd1;
                end
                else if (item.cycle_index == CYC_3)
                begin
                    align    = 1'b1;
                    cpu.addr = cpu.addr + 16'd1;
                    if (item.cond_true)
                        pc = {item.read_byte, cpu.temp[7:0]};
                    done = 1'b1;
                end
            end
            FUNC_CALL:
            begin
                if (item.cycle_index == CYC_1)
                begin
                    cpu.kind = KIND_READ;
                    cpu.addr = pc;
                end
                else if (item.cycle_index == CYC_2)
                begin
                    cpu.temp[7:0] = item.read_byte;
                    cpu.addr      = cpu.addr + 16'd1;
                end
                else if (item.cycle_index == CYC_3)
                begin
                    align          = 1'b1;
                    cpu.temp[15:8] = item.read_byte;
                    cpu.addr       = cpu.addr + 16'd1;
                    pc             = cpu.addr;
                    if (item.cond_true)
                    begin
                        cpu.kind  = KIND_WRITE;
                        cpu.addr  = sp - 16'd1;
                        cpu.wdata = pc[15:8];
                    end
                    else
                        done = 1'b1;
                end
                else if (item.cycle_index == CYC_4)
                begin
                    cpu.addr  = cpu.addr - 16'd1;
                    cpu.wdata = pc[7:0];
                end
                else if (item.cycle_index == CYC_5)
                begin
                    sp   = cpu.addr;
                    pc   = cpu.temp;
                    done = 1'b1;
                end
            end
            FUNC_RST:
            begin
                if (item.cycle_index == CYC_1)
                begin
                    cpu.kind  = KIND_WRITE;
                    cpu.addr  = sp - 16'd1;
                    cpu.wdata = pc[15:8];
                end
                else if (item.cycle_index == CYC_2)
                begin
                    cpu.addr  = cpu.addr - 16'd1;
                    cpu.wdata = pc[7:0];
                end
                else if (item.cycle_index == CYC_3)
                begin
                    cpu.kind = KIND_INTERNAL;
                    sp       = cpu.addr;
                end
                else if (item.cycle_index == CYC_4)
                begin
                    pc    = {8'h00, item.restart_target};
                    align = 1'b1;
                end
                else if (item.cycle_index == CYC_5)
                    done = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (done)
            cpu.kind = KIND_FETCH;
        r.next_bus_kind = cpu.kind;
        r.bus_address   = cpu.addr;
        r.write_byte    = cpu.wdata;
        r.pc_out        = pc;
        r.sp_out        = sp;
        r.int_align     = align;
        r.finished      = done;
        return r;
    endfunction

    task automatic send_item(input in_item_t item, output out_item_t result);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid          <= 1'b1;
        in_ch.func           <= item.func;
        in_ch.cond_true      <= item.cond_true;
        in_ch.cycle_index    <= item.cycle_index;
        in_ch.read_byte      <= item.read_byte;
        in_ch.restart_target <= item.restart_target;
        in_ch.pc_in          <= item.pc_in;
        in_ch.sp_in          <= item.sp_in;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        result = predict_cycle(item);
        pending_results.push_back(result);
        if (is_active(item))
            active_items++;
    endtask

    task automatic step_cpu(input logic [2:0] func, input logic cond, input logic [2:0] cyc,
                            input logic [7:0] rd, input logic [7:0] target);
        in_item_t  item;
        out_item_t result;
        item.func           = func;
        item.cond_true      = cond;
        item.cycle_index    = cyc;
        item.read_byte      = rd;
        item.restart_target = target;
        item.pc_in          = cur_pc;
        item.sp_in          = cur_sp;
        send_item(item, result);
        cur_pc = result.pc_out;
        cur_sp = result.sp_out;
    endtask

    task automatic run_instruction(input func_t f, input logic cond, input int stop,
                                   input int flip_at, input logic [7:0] target,
                                   input logic [7:0] lo, input logic [7:0] hi);
        logic [7:0] rd;
        for (int c = 1; c <= stop; c++)
        begin
            rd = (c == CYC_2) ? lo : (c == CYC_3) ? hi : 8'($urandom);
            step_cpu(f, (c == flip_at) ? !cond : cond, c[2:0], rd, target);
        end
    endtask

    task automatic test_instructions();
        cur_pc = 16'h0000;
        cur_sp = 16'hFFFF;
        run_instruction(FUNC_JR, 1'b1, CYC_3, 0, 8'h00, 8'h7F, 8'h80);
        run_instruction(FUNC_RET, 1'b1, CYC_3, 0, 8'h00, 8'hFF, 8'hFF);
        cur_sp = 16'h0000;
        run_instruction(FUNC_RST, 1'b1, CYC_5, 0, 8'hFF, 8'hAA, 8'h55);
    endtask

    task automatic test_untaken_paths();
        cur_pc = 16'hFFFE;
        cur_sp = 16'h1234;
        run_instruction(FUNC_RETC, 1'b0, CYC_2, 0, 8'h00, 8'h5A, 8'hA5);
        run_instruction(FUNC_JP, 1'b0, CYC_3, 0, 8'h00, 8'h12, 8'h34);
        run_instruction(FUNC_CALL, 1'b0, CYC_3, 0, 8'h00, 8'hC3, 8'h3C);
    endtask

    task automatic test_idle_steps();
        step_cpu(FUNC_BAD_6, 1'b1, CYC_1, 8'hFF, 8'h00);
        step_cpu(FUNC_BAD_7, 1'b0, CYC_2, 8'h00, 8'hFF);
        step_cpu(FUNC_RET, 1'b1, CYC_NONE, 8'h81, 8'h18);
        step_cpu(FUNC_JR, 1'b1, CYC_7, 8'h42, 8'h24);
    endtask

    task automatic test_random_sequences();
        int         sel;
        func_t      f;
        logic       cond;
        logic [2:0] last;
        logic [7:0] target;
        while (active_items < RANDOM_ITEMS)
        begin
            sel    = $urandom_range(0, 9);
            f      = func_t'($urandom_range(FUNC_JR, FUNC_RST));
            cond   = 1'($urandom_range(0, 1));
            last   = last_cycle(f, cond);
            target = 8'($urandom);
            if ($urandom_range(0, 3) == 0)
            begin
                cur_pc = pick_word();
                cur_sp = pick_word();
            end
            if (sel < 7)
                run_instruction(f, cond, last, 0, target, 8'($urandom), 8'($urandom));
            else if (sel == 7)
                run_instruction(f, cond, $urandom_range(1, last), $urandom_range(0, last),
                                target, 8'($urandom), 8'($urandom));
            else
                repeat ($urandom_range(1, 3))
                    step_cpu(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                             3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t result with none pending: expected none, actual pc %h sp %h",
                         $time, out_ch.pc_out, out_ch.sp_out);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("next_bus_kind", 16'(want.next_bus_kind), 16'(out_ch.next_bus_kind));
                check_field("bus_address", want.bus_address, out_ch.bus_address);
                check_field("write_byte", 16'(want.write_byte), 16'(out_ch.write_byte));
                check_field("pc_out", want.pc_out, out_ch.pc_out);
                check_field("sp_out", want.sp_out, out_ch.sp_out);
                check_field("int_align", 16'(want.int_align), 16'(out_ch.int_align));
                check_field("finished", 16'(want.finished), 16'(out_ch.finished));
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  <= $urandom_range(0, 3);
            stall_phase <= $urandom_range(16, 80);
        end
        else
            stall_phase <= stall_phase - 1;
        case (stall_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
            2:       out_ch.ready <= (stall_phase[1:0] != 2'b00);
            default: out_ch.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.func           <= FUNC_JR;
        in_ch.cond_true      <= 1'b0;
        in_ch.cycle_index    <= CYC_NONE;
        in_ch.read_byte      <= 8'h00;
        in_ch.restart_target <= 8'h00;
        in_ch.pc_in          <= 16'h0000;
        in_ch.sp_in          <= 16'h0000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_instructions();
        test_untaken_paths();
        test_idle_steps();
        test_random_sequences();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
